/* hw/rtl/gmvf_pkg.sv */
`default_nettype none

package gmvf_pkg;

    localparam int DataW  = 64;
    localparam int TagW   = 32;
    localparam int CountW = 16;
    localparam int ModeW  = 2;

    localparam int ValueBitsDefault = 64;
    localparam int RunMaxDefault    = 65535;

    typedef enum logic [ModeW-1:0] {
        MODE_PASS = 2'd0,
        MODE_FWD  = 2'd1,
        MODE_BWD  = 2'd2,
        MODE_BOTH = 2'd3
    } fill_mode_t;

    localparam fill_mode_t ModeReset = MODE_FWD;

endpackage

`default_nettype wire

/* hw/rtl/gmvf_in_if.sv */
`default_nettype none

interface gmvf_in_if;
    logic                        valid;
    logic                        ready;
    logic [gmvf_pkg::DataW-1:0]  data_value;
    logic                        data_missing;
    logic                        group_first;
    logic                        group_last;
    logic [gmvf_pkg::TagW-1:0]   row_tag;

    modport source (
        output valid, data_value, data_missing, group_first, group_last, row_tag,
        input  ready
    );

    modport sink (
        input  valid, data_value, data_missing, group_first, group_last, row_tag,
        output ready
    );
endinterface

`default_nettype wire

/* hw/rtl/gmvf_out_if.sv */
`default_nettype none

interface gmvf_out_if;
    logic                        valid;
    logic                        ready;
    logic [gmvf_pkg::DataW-1:0]  run_value;
    logic                        run_missing;
    logic [gmvf_pkg::CountW-1:0] run_count;
    logic [gmvf_pkg::TagW-1:0]   run_end_tag;
    logic                        run_closes_group;
    logic                        run_overflow;

    modport source (
        output valid, run_value, run_missing, run_count, run_end_tag, run_closes_group,
               run_overflow,
        input  ready
    );

    modport sink (
        input  valid, run_value, run_missing, run_count, run_end_tag, run_closes_group,
               run_overflow,
        output ready
    );
endinterface

`default_nettype wire

/* hw/rtl/grouped_missing_value_fill.sv */
// grouped missing-value fill: takes one element per cycle and gives at most one run-length
// result per element, through the input register and then the result register.
// The rate is set by the single update of carried value and pending count between the two
// registers, so back-to-back elements never stall unless the result side holds off ready.
// In backward fill, and in both-ways fill before a group's first value, missing elements are
// only counted; the next present value, or the group's last element, closes the run with a
// count covering them. A run that reaches RUN_MAX is sent unfilled with run_overflow set.
// group_first and group_last clear the carried value and pending count; a fill_mode write
// does too; the user makes it only while the block is idle; the block does not enforce it.
`default_nettype none

module grouped_missing_value_fill #(
    parameter int VALUE_BITS = gmvf_pkg::ValueBitsDefault,
    parameter int RUN_MAX    = gmvf_pkg::RunMaxDefault
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     cfg_we,
    input  wire logic [gmvf_pkg::ModeW-1:0] cfg_wdata,
    gmvf_in_if.sink                       in_ch,
    gmvf_out_if.source                    out_ch
);

    localparam int CntW = gmvf_pkg::CountW;

    gmvf_pkg::fill_mode_t mode_reg;

    // input register
    logic                          s1_valid_reg;
    logic [VALUE_BITS-1:0]         s1_value_reg;
    logic                          s1_missing_reg;
    logic                          s1_first_reg;
    logic                          s1_last_reg;
    logic [gmvf_pkg::TagW-1:0]     s1_tag_reg;

    // fill state
    logic [VALUE_BITS-1:0]         carried_value_reg, carried_value_next;
    logic                          carried_valid_reg, carried_valid_next;
    logic [CntW-1:0]               pending_reg, pending_next;

    // result register
    logic                          out_valid_reg;
    logic [VALUE_BITS-1:0]         out_value_reg;
    logic                          out_missing_reg;
    logic [CntW-1:0]               out_count_reg;
    logic [gmvf_pkg::TagW-1:0]     out_tag_reg;
    logic                          out_closes_reg;
    logic                          out_overflow_reg;

    logic                          advance;
    logic                          process;

    logic [VALUE_BITS-1:0]         cv;
    logic                          cvalid;
    logic [CntW-1:0]               pend;
    logic [CntW:0]                 pend_inc;

    logic                          res_emit;
    logic [VALUE_BITS-1:0]         res_value;
    logic                          res_missing;
    logic [CntW-1:0]               res_count;
    logic                          res_overflow;

    assign advance     = !out_valid_reg || out_ch.ready;
    assign process     = s1_valid_reg && advance;
    assign in_ch.ready = !s1_valid_reg || advance;

    always_comb
    begin
        // group_first clears the state before the element is handled
        cv       = s1_first_reg ? '0 : carried_value_reg;
        cvalid   = s1_first_reg ? 1'b0 : carried_valid_reg;
        pend     = s1_first_reg ? '0 : pending_reg;
        pend_inc = {1'b0, pend} + (CntW+1)'(1);

        res_emit           = 1'b1;
        res_value          = '0;
        res_missing        = 1'b0;
        res_count          = CntW'(1);
        res_overflow       = 1'b0;
        carried_value_next = cv;
        carried_valid_next = cvalid;
        pending_next       = pend;

        if (mode_reg == gmvf_pkg::MODE_PASS)
        begin
            res_value   = s1_missing_reg ? '0 : s1_value_reg;
            res_missing = s1_missing_reg;
        end
        else if (!s1_missing_reg)
        begin
            res_value          = s1_value_reg;
            res_count          = pend_inc[CntW-1:0];
            pending_next       = '0;
            carried_value_next = s1_value_reg;
            carried_valid_next = 1'b1;
        end
        else if (mode_reg == gmvf_pkg::MODE_FWD || (mode_reg == gmvf_pkg::MODE_BOTH && cvalid))
        begin
            res_value   = cvalid ? cv : '0;
            res_missing = !cvalid;
        end
        else if (s1_last_reg)
        begin
            res_missing  = 1'b1;
            res_count    = pend_inc[CntW-1:0];
            pending_next = '0;
        end
        else if (pend_inc >= (CntW+1)'(RUN_MAX))
        begin
            res_missing  = 1'b1;
            res_count    = pend_inc[CntW-1:0];
            res_overflow = 1'b1;
            pending_next = '0;
        end
        else
        begin
            res_emit     = 1'b0;
            pending_next = pend_inc[CntW-1:0];
        end

        // group_last clears it after
        if (s1_last_reg)
        begin
            carried_value_next = '0;
            carried_valid_next = 1'b0;
            pending_next       = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg          <= gmvf_pkg::ModeReset;
            carried_value_reg <= '0;
            carried_valid_reg <= 1'b0;
            pending_reg       <= '0;
            s1_valid_reg      <= 1'b0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                mode_reg          <= gmvf_pkg::fill_mode_t'(cfg_wdata);
                carried_value_reg <= '0;
                carried_valid_reg <= 1'b0;
                pending_reg       <= '0;
            end
            else if (process)
            begin
                carried_value_reg <= carried_value_next;
                carried_valid_reg <= carried_valid_next;
                pending_reg       <= pending_next;
            end

            if (in_ch.ready)
            begin
                s1_valid_reg <= in_ch.valid;
            end

            if (advance)
            begin
                out_valid_reg <= process && res_emit;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ch.valid && in_ch.ready)
        begin
            s1_value_reg   <= in_ch.data_value[VALUE_BITS-1:0];
            s1_missing_reg <= in_ch.data_missing;
            s1_first_reg   <= in_ch.group_first;
            s1_last_reg    <= in_ch.group_last;
            s1_tag_reg     <= in_ch.row_tag;
        end

        if (process && res_emit)
        begin
            out_value_reg    <= res_value;
            out_missing_reg  <= res_missing;
            out_count_reg    <= res_count;
            out_tag_reg      <= s1_tag_reg;
            out_closes_reg   <= s1_last_reg;
            out_overflow_reg <= res_overflow;
        end
    end

    assign out_ch.valid            = out_valid_reg;
    assign out_ch.run_value        = gmvf_pkg::DataW'(out_value_reg);
    assign out_ch.run_missing      = out_missing_reg;
    assign out_ch.run_count        = out_count_reg;
    assign out_ch.run_end_tag      = out_tag_reg;
    assign out_ch.run_closes_group = out_closes_reg;
    assign out_ch.run_overflow     = out_overflow_reg;

    // a missing run never carries a value
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_missing_reg |-> out_value_reg == '0)
        else $error("missing run with nonzero value");

    // overflow runs are unfilled and never the group's closing run
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_overflow_reg |-> out_missing_reg && !out_closes_reg)
        else $error("bad overflow run");

    // pending count stays below the run limit
    assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg |-> {1'b0, pending_reg} < (CntW+1)'(RUN_MAX))
        else $error("pending count reached run limit");

    // an element that closes its group leaves nothing behind
    assert property (@(posedge clk) disable iff (!rst_n)
        process && s1_last_reg && !cfg_we |=> pending_reg == '0 && !carried_valid_reg)
        else $error("state not cleared at group end");

endmodule

`default_nettype wire
